// ===== sv/pkalm_pkg.sv =====
// Package: shared constants, codes and types for the peer keepalive liveness monitor.
`timescale 1ns / 1ps

package pkalm_pkg;

   localparam int MAX_NODES = 32;
   localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int IDX_W     = $clog2(MAX_NODES + 1);

   localparam int OP_W      = 2;
   localparam int PEER_W    = 5;
   localparam int ACTION_W  = 2;
   localparam int COUNT_W   = 8;
   localparam int NIU_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam int CQ_DEPTH  = 4;
   localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);

   localparam logic [OP_W-1:0] OP_RX   = 2'd0;
   localparam logic [OP_W-1:0] OP_TX   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MONITOR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES_IN_USE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_LIMIT     = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE      = 2'd0,
      ACT_RECONNECT = 2'd1,
      ACT_DEAD      = 2'd2,
      ACT_KEEPALIVE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CMD_RX   = 2'd0,
      CMD_TX   = 2'd1,
      CMD_TICK = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [PEER_W-1:0]       peer;
      logic [IDX_W-1:0]        walk;
   } cmd_type;

   typedef struct packed {
      logic                    monitor_enable;
      logic [PEER_W-1:0]       own_node;
      logic [NIU_W-1:0]        nodes_in_use;
      logic [COUNT_W-1:0]      miss_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } walk_state_type;

endpackage

// ===== sv/peer_keepalive_liveness_monitor_top.sv =====
// Top level: configuration registers and the front end, command queue and back end.
`timescale 1ns / 1ps

// Peer keepalive liveness monitor. Receive and send activity transactions
// set per-peer flags and produce no result; the back end takes them from
// the queue only while idle, and a four-entry command queue between decode
// and the peer table absorbs bursts. An interval tick walks peer entries 0
// to nodes_in_use-1 (clamped to the table size), one entry per cycle,
// skipping own_node, and returns one result per peer with last set on the
// final one; the walk pauses whenever the single result register is still
// waiting to be popped. Ticks with monitoring disabled and unused op codes
// are dropped at decode. The user must write configuration through the csr
// port only while the block is idle; the block itself does not enforce it.

module peer_keepalive_liveness_monitor_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [pkalm_pkg::OP_W-1:0]          req_op,
   input  logic [pkalm_pkg::PEER_W-1:0]        req_peer,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [pkalm_pkg::PEER_W-1:0]        rsp_peer_index,
   output logic [pkalm_pkg::ACTION_W-1:0]      rsp_action,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [pkalm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pkalm_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   pkalm_pkg::cfg_type  cfg_ff;
   pkalm_pkg::cfg_type  cfg_in;
   pkalm_pkg::cmd_type  push_data;
   pkalm_pkg::cmd_type  pop_data;
   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pkalm_pkg::CSR_MONITOR_ENABLE: cfg_in.monitor_enable = csr_wdata[0];
            pkalm_pkg::CSR_OWN_NODE:       cfg_in.own_node =
                                              csr_wdata[pkalm_pkg::PEER_W-1:0];
            pkalm_pkg::CSR_NODES_IN_USE:   cfg_in.nodes_in_use =
                                              csr_wdata[pkalm_pkg::NIU_W-1:0];
            pkalm_pkg::CSR_MISS_LIMIT:     cfg_in.miss_limit = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.monitor_enable <= 1'b1;
         cfg_ff.own_node       <= '0;
         cfg_ff.nodes_in_use   <= pkalm_pkg::NIU_W'(32);
         cfg_ff.miss_limit     <= pkalm_pkg::COUNT_W'(5);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pkalm_front u_front (
      .req_push (req_push),
      .req_op   (req_op),
      .req_peer (req_peer),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .req_full (req_full),
      .q_push   (q_push),
      .q_data   (push_data)
   );

   pkalm_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   pkalm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_data         (pop_data),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_peer_index (rsp_peer_index),
      .rsp_action     (rsp_action),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== sv/pkalm_front.sv =====
// Front end: accepts input transactions, decodes them and queues the ones that do work.
`timescale 1ns / 1ps

module pkalm_front (
   input  logic                       req_push,
   input  logic [pkalm_pkg::OP_W-1:0]   req_op,
   input  logic [pkalm_pkg::PEER_W-1:0] req_peer,
   input  pkalm_pkg::cfg_type         cfg,
   input  logic                       q_full,
   output logic                       req_full,
   output logic                       q_push,
   output pkalm_pkg::cmd_type         q_data
);

   logic accept;
   logic keep;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      keep           = 1'b0;
      q_data.kind    = pkalm_pkg::CMD_RX;
      q_data.peer    = req_peer;
      q_data.walk    = '0;
      unique case (req_op)
         pkalm_pkg::OP_RX: begin
            keep        = 1'b1;
            q_data.kind = pkalm_pkg::CMD_RX;
         end
         pkalm_pkg::OP_TX: begin
            keep        = 1'b1;
            q_data.kind = pkalm_pkg::CMD_TX;
         end
         pkalm_pkg::OP_TICK: begin
            keep        = cfg.monitor_enable;
            q_data.kind = pkalm_pkg::CMD_TICK;
         end
         default: keep = 1'b0;
      endcase
      if (32'(cfg.nodes_in_use) > pkalm_pkg::MAX_NODES) begin
         q_data.walk = pkalm_pkg::IDX_W'(pkalm_pkg::MAX_NODES);
      end else begin
         q_data.walk = pkalm_pkg::IDX_W'(cfg.nodes_in_use);
      end
   end

   assign q_push = accept && keep;

endmodule

// ===== sv/pkalm_cmd_queue.sv =====
// Command queue: short FIFO between the decode front end and the peer table back end.
`timescale 1ns / 1ps

module pkalm_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pkalm_pkg::cmd_type  push_data,
   input  logic                pop,
   output pkalm_pkg::cmd_type  pop_data,
   output logic                full,
   output logic                empty
);

   pkalm_pkg::cmd_type                 mem_ff [pkalm_pkg::CQ_DEPTH];
   logic [pkalm_pkg::CQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pkalm_pkg::CQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pkalm_pkg::CQ_PTR_W:0]       count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full     = (32'(count_ff) == pkalm_pkg::CQ_DEPTH);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/pkalm_back.sv =====
// Back end: peer table, activity updates and the per-tick liveness walk with result register.
`timescale 1ns / 1ps

module pkalm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  pkalm_pkg::cfg_type               cfg,
   input  logic                             q_empty,
   input  pkalm_pkg::cmd_type               q_data,
   output logic                             q_pop,
   input  logic                             rsp_pop,
   output logic                             rsp_empty,
   output logic [pkalm_pkg::PEER_W-1:0]     rsp_peer_index,
   output logic [pkalm_pkg::ACTION_W-1:0]   rsp_action,
   output logic                             rsp_last
);

   localparam int IDX_W   = pkalm_pkg::IDX_W;
   localparam int NODE_W  = pkalm_pkg::NODE_W;
   localparam int COUNT_W = pkalm_pkg::COUNT_W;

   logic [pkalm_pkg::MAX_NODES-1:0]   rx_ff;
   logic [pkalm_pkg::MAX_NODES-1:0]   tx_ff;
   logic [pkalm_pkg::MAX_NODES-1:0]   conn_ff;
   logic [COUNT_W-1:0]                mc_ff [pkalm_pkg::MAX_NODES];

   pkalm_pkg::walk_state_type          st_ff, st_in;
   logic [IDX_W-1:0]                   idx_ff, idx_in;
   logic [IDX_W-1:0]                   walk_ff, walk_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pkalm_pkg::PEER_W-1:0]       rsp_peer_ff;
   pkalm_pkg::action_type              rsp_action_ff;
   logic                               rsp_last_ff;

   logic                               set_rx;
   logic                               set_tx;
   logic                               do_check;
   logic                               slot_free;
   logic                               peer_ok;
   logic [NODE_W-1:0]                  ev_sel;
   logic [NODE_W-1:0]                  k;
   logic [IDX_W-1:0]                   own_idx;
   logic [IDX_W:0]                     idx_p1;
   logic [IDX_W:0]                     walk_x;
   logic                               is_last;

   logic                               conn_n;
   logic                               rx_n;
   logic                               tx_n;
   logic [COUNT_W-1:0]                 mc_n;
   logic [COUNT_W-1:0]                 mc_step;
   pkalm_pkg::action_type              act_n;

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_peer_index = rsp_peer_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_last       = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign peer_ok   = (32'(q_data.peer) < pkalm_pkg::MAX_NODES);
   assign ev_sel    = NODE_W'(q_data.peer);
   assign k         = idx_ff[NODE_W-1:0];
   assign own_idx   = IDX_W'(cfg.own_node);
   assign idx_p1    = {1'b0, idx_ff} + 1'b1;
   assign walk_x    = {1'b0, walk_ff};
   assign is_last   = (idx_p1 >= walk_x)
                   || ((idx_p1 == {1'b0, own_idx}) && ((idx_p1 + 1'b1) >= walk_x));

   // liveness check of the entry under the walk index
   always_comb begin
      conn_n  = conn_ff[k];
      rx_n    = rx_ff[k];
      tx_n    = tx_ff[k];
      mc_n    = mc_ff[k];
      act_n   = pkalm_pkg::ACT_NONE;
      mc_step = '0;
      if (!conn_ff[k]) begin
         if (rx_ff[k]) begin
            conn_n = 1'b1;
            mc_n   = '0;
            act_n  = pkalm_pkg::ACT_RECONNECT;
         end
      end else begin
         if (rx_ff[k]) begin
            mc_step = '0;
         end else if (mc_ff[k] == pkalm_pkg::COUNT_MAX) begin
            mc_step = mc_ff[k];
         end else begin
            mc_step = mc_ff[k] + 1'b1;
         end
         rx_n = 1'b0;
         if (mc_step >= cfg.miss_limit) begin
            conn_n = 1'b0;
            mc_n   = '0;
            act_n  = pkalm_pkg::ACT_DEAD;
         end else begin
            mc_n  = mc_step;
            act_n = tx_ff[k] ? pkalm_pkg::ACT_NONE : pkalm_pkg::ACT_KEEPALIVE;
            tx_n  = 1'b0;
         end
      end
   end

   always_comb begin
      st_in    = st_ff;
      idx_in   = idx_ff;
      walk_in  = walk_ff;
      q_pop    = 1'b0;
      set_rx   = 1'b0;
      set_tx   = 1'b0;
      do_check = 1'b0;
      unique case (st_ff)
         pkalm_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_data.kind)
                  pkalm_pkg::CMD_RX: set_rx = peer_ok;
                  pkalm_pkg::CMD_TX: set_tx = peer_ok;
                  pkalm_pkg::CMD_TICK: begin
                     walk_in = q_data.walk;
                     idx_in  = '0;
                     st_in   = pkalm_pkg::ST_WALK;
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         pkalm_pkg::ST_WALK: begin
            if (idx_ff >= walk_ff) begin
               st_in = pkalm_pkg::ST_IDLE;
            end else if (idx_ff == own_idx) begin
               idx_in = idx_p1[IDX_W-1:0];
            end else if (slot_free) begin
               do_check = 1'b1;
               idx_in   = idx_p1[IDX_W-1:0];
            end
         end
         default: st_in = pkalm_pkg::ST_IDLE;
      endcase
      if (do_check) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= pkalm_pkg::ST_IDLE;
         idx_ff       <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rx_ff        <= '0;
         tx_ff        <= '0;
         conn_ff      <= '0;
         for (int i = 0; i < pkalm_pkg::MAX_NODES; i++) begin
            mc_ff[i] <= '0;
         end
      end else begin
         st_ff        <= st_in;
         idx_ff       <= idx_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (set_rx) begin
            rx_ff[ev_sel] <= 1'b1;
         end
         if (set_tx) begin
            tx_ff[ev_sel] <= 1'b1;
         end
         if (do_check) begin
            rx_ff[k]   <= rx_n;
            tx_ff[k]   <= tx_n;
            conn_ff[k] <= conn_n;
            mc_ff[k]   <= mc_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_check) begin
         rsp_peer_ff   <= pkalm_pkg::PEER_W'(k);
         rsp_action_ff <= act_n;
         rsp_last_ff   <= is_last;
      end
   end

endmodule
